[design/rwh_pkg.sv]
package rwh_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W      = $clog2(WINDOW_MAX + 1);

    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 31;
    localparam int LEN_FIELD_W = 7;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int LCMP_W      = (FILL_W > LEN_FIELD_W) ? FILL_W : LEN_FIELD_W;

    // shared multiply and reduce unit: 64-bit accumulator, two bits per step
    localparam int MM_PROD_W   = 2 * HASH_W;
    localparam int MM_ACC_W    = 64;
    localparam int MM_STEPS    = MM_ACC_W / 2;
    localparam int MM_CNT_W    = $clog2(MM_STEPS);

    localparam logic [HASH_W-1:0] BASE_RESET    = HASH_W'(256);
    localparam logic [HASH_W-1:0] MODULUS_RESET = HASH_W'(1000000007);
    localparam logic [LEN_FIELD_W-1:0] LENGTH_RESET = LEN_FIELD_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_BASE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODULUS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(2);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_of_string;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0] window_hash;
        logic              window_full;
    } out_item_t;

    // operands of one (x * y + c) mod m operation
    typedef struct packed {
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] y;
        logic [HASH_W-1:0] c;
        logic [HASH_W-1:0] m;
    } mm_req_t;

    function automatic logic [HASH_W-1:0] eff_modulus(input logic [HASH_W-1:0] m);
        if (m < HASH_W'(2))
            return HASH_W'(2);
        else
            return m;
    endfunction

    function automatic logic [FILL_W-1:0] eff_len(input logic [LEN_FIELD_W-1:0] wl);
        logic [LCMP_W-1:0] wl_x;
        wl_x = LCMP_W'(wl);
        if (wl == '0)
            return FILL_W'(1);
        else if (wl_x > LCMP_W'(WINDOW_MAX))
            return FILL_W'(WINDOW_MAX);
        else
            return FILL_W'(wl);
    endfunction

endpackage

[design/rwh_ram.sv]
module rwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/rwh_mulmod.sv]
module rwh_mulmod
    import rwh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mm_req_t           req,
    output logic              done,
    output logic [HASH_W-1:0] result
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_ADD  = 3'b010,
        U_RED  = 3'b100
    } mm_state_t;

    mm_state_t state_reg, state_next;
    logic [MM_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [MM_PROD_W-1:0] prod_reg, prod_next;
    logic [HASH_W-1:0]    c_reg, c_next;
    logic [HASH_W-1:0]    m_reg, m_next;
    logic [HASH_W:0]      m2_reg, m2_next;
    logic [HASH_W+1:0]    m3_reg, m3_next;
    logic [MM_ACC_W-1:0]  acc_reg, acc_next;
    logic [HASH_W-1:0]    rem_reg, rem_next;

    logic [HASH_W+1:0] v;
    logic [HASH_W+2:0] d1, d2, d3;

    // radix-4 restoring step: remainder stays below m, 4r + digit below 4m
    assign v  = {rem_reg, acc_reg[MM_ACC_W-1 -: 2]};
    assign d1 = {1'b0, v} - (HASH_W+3)'(m_reg);
    assign d2 = {1'b0, v} - (HASH_W+3)'(m2_reg);
    assign d3 = {1'b0, v} - (HASH_W+3)'(m3_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        c_next     = c_reg;
        m_next     = m_reg;
        m2_next    = m2_reg;
        m3_next    = m3_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    prod_next  = MM_PROD_W'(req.x) * MM_PROD_W'(req.y);
                    c_next     = req.c;
                    m_next     = req.m;
                    state_next = U_ADD;
                end
            end
            U_ADD:
            begin
                acc_next   = MM_ACC_W'(prod_reg) + MM_ACC_W'(c_reg);
                m2_next    = {m_reg, 1'b0};
                m3_next    = (HASH_W+2)'({m_reg, 1'b0}) + (HASH_W+2)'(m_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = U_RED;
            end
            U_RED:
            begin
                priority if (!d3[HASH_W+2])
                    rem_next = HASH_W'(d3);
                else if (!d2[HASH_W+2])
                    rem_next = HASH_W'(d2);
                else if (!d1[HASH_W+2])
                    rem_next = HASH_W'(d1);
                else
                    rem_next = HASH_W'(v);
                acc_next = acc_reg << 2;
                cnt_next = cnt_reg + MM_CNT_W'(1);
                if (cnt_reg == MM_CNT_W'(MM_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        c_reg    <= c_next;
        m_reg    <= m_next;
        m2_reg   <= m2_next;
        m3_reg   <= m3_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

[design/rolling_window_hash_core.sv]
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_data  (data_byte, start_of_string)
// out       output     out_valid / out_stall  out_data (window_hash, window_full)
// cfg       input      cfg_wr_en              cfg_index, cfg_data
//
// each item goes through one shared (x*y + c) mod m unit
// first byte of a string: one operation
// later bytes: two dependent operations, whether or not the window is full; in_stall is high meanwhile
// after reset or any register write the first item adds one operation to reduce the base
// a finished result waits in the output register; the next item is taken meanwhile
// rst_n clears all control state and loads the register reset values
module rolling_window_hash_core
    import rwh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_BASE = 9'b000000100,
        S_SUB  = 9'b000001000,
        S_TSUB = 9'b000010000,
        S_ROLL = 9'b000100000,
        S_POW  = 9'b001000000,
        S_HORN = 9'b010000000,
        S_FIN  = 9'b100000000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic [HASH_W-1:0]      base_cfg_reg, base_cfg_next;
    logic [HASH_W-1:0]      mod_cfg_reg, mod_cfg_next;
    logic [LEN_FIELD_W-1:0] len_cfg_reg, len_cfg_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic [HASH_W-1:0]      pow_reg, pow_next;
    logic                   base_ok_reg, base_ok_next;
    logic                   out_valid_reg, out_valid_next;

    logic [HASH_W-1:0]      base_r_reg, base_r_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic [HASH_W-1:0]      t_reg, t_next;
    out_item_t              out_data_reg, out_data_next;

    logic [HASH_W-1:0] m_eff;
    logic [FILL_W-1:0] len_eff;
    logic              full;
    logic              cfg_hit;
    logic              issue_first;
    logic [HASH_W-1:0] base_sel;
    logic [HASH_W:0]   t_sum;
    logic [FILL_W-1:0] ptr_inc;

    logic              mm_start;
    mm_req_t           mm_req;
    logic              mm_done;
    logic [HASH_W-1:0] mm_result;

    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;

    assign m_eff    = eff_modulus(mod_cfg_reg);
    assign len_eff  = eff_len(len_cfg_reg);
    assign full     = (fill_reg >= len_eff);
    assign cfg_hit  = cfg_wr_en && ((cfg_index == CFG_HASH_BASE) ||
                      (cfg_index == CFG_HASH_MODULUS) || (cfg_index == CFG_WINDOW_LENGTH));
    assign base_sel = base_ok_reg ? base_r_reg : mm_result;
    // h + m - sub lies in 1..2m-1
    assign t_sum    = (HASH_W+1)'(hash_reg) + (HASH_W+1)'(m_eff) - (HASH_W+1)'(mm_result);
    assign ptr_inc  = FILL_W'(ptr_reg) + FILL_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        base_cfg_next  = base_cfg_reg;
        mod_cfg_next   = mod_cfg_reg;
        len_cfg_next   = len_cfg_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        hash_next      = hash_reg;
        pow_next       = pow_reg;
        base_ok_next   = base_ok_reg;
        base_r_next    = base_r_reg;
        byte_next      = byte_reg;
        t_next         = t_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        issue_first    = 1'b0;
        mm_start       = 1'b0;
        mm_req.x       = hash_reg;
        mm_req.y       = base_r_reg;
        mm_req.c       = HASH_W'(byte_reg);
        mm_req.m       = m_eff;
        ram_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = in_data.data_byte;
                    if (in_data.start_of_string)
                    begin
                        ptr_next  = '0;
                        fill_next = '0;
                        hash_next = '0;
                        pow_next  = HASH_W'(1);
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (base_ok_reg)
                begin
                    issue_first = 1'b1;
                end
                else
                begin
                    // base mod m, kept until the next register write
                    mm_start   = 1'b1;
                    mm_req.x   = base_cfg_reg;
                    mm_req.y   = HASH_W'(1);
                    mm_req.c   = '0;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                if (mm_done)
                begin
                    base_r_next  = mm_result;
                    base_ok_next = 1'b1;
                    issue_first  = 1'b1;
                end
            end
            S_SUB:
            begin
                if (mm_done)
                begin
                    if (t_sum >= (HASH_W+1)'(m_eff))
                        t_next = HASH_W'(t_sum - (HASH_W+1)'(m_eff));
                    else
                        t_next = HASH_W'(t_sum);
                    state_next = S_TSUB;
                end
            end
            S_TSUB:
            begin
                mm_start   = 1'b1;
                mm_req.x   = t_reg;
                state_next = S_ROLL;
            end
            S_ROLL:
            begin
                if (mm_done)
                begin
                    hash_next  = mm_result;
                    state_next = S_FIN;
                end
            end
            S_POW:
            begin
                if (mm_done)
                begin
                    pow_next   = mm_result;
                    mm_start   = 1'b1;
                    state_next = S_HORN;
                end
            end
            S_HORN:
            begin
                if (mm_done)
                begin
                    hash_next  = mm_result;
                    fill_next  = fill_reg + FILL_W'(1);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.window_hash = hash_reg;
                    out_data_next.window_full = full;
                    ram_we                    = 1'b1;
                    ptr_next   = (ptr_inc >= len_eff) ? '0 : PTR_W'(ptr_inc);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (issue_first)
        begin
            mm_start = 1'b1;
            priority if (full)
            begin
                // remove the outgoing byte times the power
                mm_req.x   = HASH_W'(ram_rdata);
                mm_req.y   = pow_reg;
                mm_req.c   = '0;
                state_next = S_SUB;
            end
            else if (fill_reg != '0)
            begin
                mm_req.x   = pow_reg;
                mm_req.y   = base_sel;
                mm_req.c   = '0;
                state_next = S_POW;
            end
            else
            begin
                mm_req.y   = base_sel;
                state_next = S_HORN;
            end
        end

        // register writes must come only while idle (not enforced); any of them restarts the string
        if (cfg_hit)
        begin
            unique case (cfg_index)
                CFG_HASH_BASE:     base_cfg_next = cfg_data;
                CFG_HASH_MODULUS:  mod_cfg_next  = cfg_data;
                CFG_WINDOW_LENGTH: len_cfg_next  = cfg_data[LEN_FIELD_W-1:0];
                default:           base_cfg_next = base_cfg_reg;
            endcase
            ptr_next     = '0;
            fill_next    = '0;
            hash_next    = '0;
            pow_next     = HASH_W'(1);
            base_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_cfg_reg  <= BASE_RESET;
            mod_cfg_reg   <= MODULUS_RESET;
            len_cfg_reg   <= LENGTH_RESET;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            hash_reg      <= '0;
            pow_reg       <= HASH_W'(1);
            base_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_cfg_reg  <= base_cfg_next;
            mod_cfg_reg   <= mod_cfg_next;
            len_cfg_reg   <= len_cfg_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            hash_reg      <= hash_next;
            pow_reg       <= pow_next;
            base_ok_reg   <= base_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_r_reg   <= base_r_next;
        byte_reg     <= byte_next;
        t_reg        <= t_next;
        out_data_reg <= out_data_next;
    end

    rwh_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .req    (mm_req),
        .done   (mm_done),
        .result (mm_result)
    );

    // read port follows the ring pointer; the outgoing byte sits at the write slot
    rwh_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (byte_reg),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/rwh_checker.sv]
module rwh_checker
    import rwh_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input out_item_t            out_data,
    input logic                 cfg_wr_en,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    logic [HASH_W-1:0] mod_reg, mod_next;
    logic [1:0]        pend_reg, pend_next;
    logic              in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        mod_next  = mod_reg;
        pend_next = pend_reg + 2'(in_acc) - 2'(out_acc);
        if (cfg_wr_en && (cfg_index == CFG_HASH_MODULUS))
        begin
            mod_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= MODULUS_RESET;
            pend_reg <= '0;
        end
        else
        begin
            mod_reg  <= mod_next;
            pend_reg <= pend_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // every hash is reduced below the effective modulus
    a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.window_hash < eff_modulus(mod_reg)))
        else $error("hash not reduced");

    // one item at a time in the sequencer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("item accepted while previous item in work");

    // at most one item in work and one result waiting
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("too many items outstanding");

    // no result without an accepted item
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pend_reg != 2'd0))
        else $error("result without item");

endmodule

bind rolling_window_hash_core rwh_checker u_rwh_checker (.*);

[tb/tb_rolling_window_hash_core.sv]
`timescale 1ns / 1ps

module tb_rolling_window_hash_core;
    import rwh_pkg::*;

    // index that maps to no register; a write there must leave the string alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam int HOLD_CYCLES = 100;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1500;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    rolling_window_hash_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the registers and the string state
    logic [HASH_W-1:0]      base_reg = BASE_RESET;
    logic [HASH_W-1:0]      mod_reg = MODULUS_RESET;
    logic [LEN_FIELD_W-1:0] len_reg = LENGTH_RESET;
    logic [BYTE_W-1:0]      window_bytes [WINDOW_MAX];
    int unsigned            wr_slot = 0;
    int unsigned            bytes_held = 0;
    longint unsigned        cur_hash = 0;
    longint unsigned        cur_power = 1;

    out_item_t pending_hashes [$];
    int        error_count = 0;
    int        burst_left = 0;

    function automatic void restart_string();
        wr_slot = 0;
        bytes_held = 0;
        cur_hash = 0;
        cur_power = 1;
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] value);
        case (idx)
            CFG_HASH_BASE:     base_reg = value[HASH_W-1:0];
            CFG_HASH_MODULUS:  mod_reg = value[HASH_W-1:0];
            CFG_WINDOW_LENGTH: len_reg = value[LEN_FIELD_W-1:0];
            default:           return;
        endcase
        restart_string();
    endfunction

    function automatic out_item_t roll_hash(input in_item_t item);
        longint unsigned m, base, h, p, sub, t;
        int unsigned     len, slot;
        out_item_t       res;
        m = (mod_reg < 2) ? 64'd2 : 64'(mod_reg);
        base = 64'(base_reg) % m;
        if (len_reg == 0)
            len = 1;
        else if (len_reg > WINDOW_MAX)
            len = WINDOW_MAX;
        else
            len = len_reg;
        if (item.start_of_string)
            restart_string();
        h = cur_hash % m;
        p = cur_power % m;
        slot = (wr_slot < len) ? wr_slot : 0;
        if (bytes_held >= len)
        begin
            // drop the oldest byte, shift, append the new one
            sub = (64'(window_bytes[slot]) * p) % m;
            t = (h + m - sub) % m;
            h = (t * base + 64'(item.data_byte)) % m;
            bytes_held = len;
        end
        else
        begin
            if (bytes_held > 0)
                p = (p * base) % m;
            h = (h * base + 64'(item.data_byte)) % m;
            bytes_held++;
        end
        window_bytes[slot] = item.data_byte;
        slot++;
        wr_slot = (slot >= len) ? 0 : slot;
        cur_hash = h;
        cur_power = p;
        res.window_hash = h[HASH_W-1:0];
        res.window_full = (bytes_held >= len);
        return res;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                write_register(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                if (pending_hashes.size() == 0)
                begin
                    $error("unexpected item: window_hash %0d window_full %0d",
                           out_data.window_hash, out_data.window_full);
                    error_count++;
                end
                else
                begin
                    want = pending_hashes.pop_front();
                    if (out_data.window_hash !== want.window_hash)
                    begin
                        $error("window_hash: expected %0d, actual %0d",
                               want.window_hash, out_data.window_hash);
                        error_count++;
                    end
                    if (out_data.window_full !== want.window_full)
                    begin
                        $error("window_full: expected %0d, actual %0d",
                               want.window_full, out_data.window_full);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_hashes.push_back(roll_hash(in_data));
        end
    end

    // receiver: free running, light, heavy, or long stretches of stall
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 400);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ($urandom_range(0, 49) == 0) ? ~out_stall : out_stall;
        endcase
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic sos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= '{data_byte: data, start_of_string: sos};
        do @(posedge clk); while (in_stall);
    endtask

    // lower valid and wait until every expected item has come back or DRAIN_LIMIT runs out, then hold
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_settings();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_clamped_registers();
        settle();
        // modulus 0 acts as 2, length 0 as 1, base 0 used as is
        write_reg(CFG_HASH_MODULUS, 31'd0);
        write_reg(CFG_HASH_BASE, 31'd0);
        write_reg(CFG_WINDOW_LENGTH, 31'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        settle();
        // modulus 1 acts as 2, length above the ring acts as the ring size
        write_reg(CFG_HASH_MODULUS, 31'd1);
        write_reg(CFG_WINDOW_LENGTH, 31'd127);
        write_reg(CFG_HASH_BASE, 31'h7FFF_FFFE);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        settle();
        write_reg(CFG_HASH_MODULUS, 31'h7FFF_FFFF);
        write_reg(CFG_WINDOW_LENGTH, 31'd2);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_small_window();
        settle();
        // base larger than modulus gets reduced first
        write_reg(CFG_HASH_BASE, 31'd1000);
        write_reg(CFG_HASH_MODULUS, 31'd7);
        write_reg(CFG_WINDOW_LENGTH, 31'd3);
        send_byte(8'h05, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h44, 1'b0);
    endtask

    task automatic test_spare_index();
        settle();
        write_reg(CFG_HASH_BASE, 31'd31);
        write_reg(CFG_HASH_MODULUS, 31'd65521);
        write_reg(CFG_WINDOW_LENGTH, 31'd2);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        settle();
        write_reg(CFG_SPARE, 31'($urandom));
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
    endtask

    task automatic random_config();
        logic [HASH_W-1:0]      modulus;
        logic [HASH_W-1:0]      base;
        logic [LEN_FIELD_W-1:0] len;
        case ($urandom_range(0, 3))
            0:       modulus = HASH_W'($urandom_range(0, 20));
            1:       modulus = HASH_W'($urandom_range(2, 100000));
            2:       modulus = ($urandom_range(0, 1) == 0) ? 31'h7FFF_FFFF : MODULUS_RESET;
            default: modulus = HASH_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       base = HASH_W'($urandom_range(0, 300));
            1:       base = HASH_W'($urandom);
            2:       base = modulus + HASH_W'($urandom_range(0, 3)) - 1'b1;
            default: base = 31'h7FFF_FFFE;
        endcase
        if ($urandom_range(0, 9) < 6)
            len = LEN_FIELD_W'($urandom_range(1, 8));
        else
            case ($urandom_range(0, 3))
                0:       len = LEN_FIELD_W'(WINDOW_MAX);
                1:       len = LEN_FIELD_W'($urandom_range(9, WINDOW_MAX - 1));
                2:       len = LEN_FIELD_W'($urandom_range(WINDOW_MAX + 1, 127));
                default: len = '0;
            endcase
        write_reg(CFG_HASH_MODULUS, modulus);
        write_reg(CFG_HASH_BASE, base);
        // upper data bits are junk for the length register
        write_reg(CFG_WINDOW_LENGTH, {24'($urandom), len});
    endtask

    task automatic test_random_phases();
        int sent;
        int n;
        int sos_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            random_config();
            n = $urandom_range(60, 250);
            sos_pct = ($urandom_range(0, 3) == 0) ? 20 : 2;
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom), ($urandom_range(0, 99) < sos_pct));
            sent += n;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_clamped_registers();
        test_small_window();
        test_spare_index();
        test_random_phases();
        settle();
        if (pending_hashes.size() != 0)
        begin
            $error("%0d expected items never arrived", pending_hashes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
